// File: hw/rtl/indexed_pixel_to_yuv420_unit_assert.svh
// Assertion macros shared by the indexed pixel to YUV 4:2:0 unit.
`ifndef INDEXED_PIXEL_TO_YUV420_UNIT_ASSERT_SVH
`define INDEXED_PIXEL_TO_YUV420_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPYUV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPYUV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ipyuv_pkg.sv
// Shared constants, types and helpers of the indexed pixel to YUV 4:2:0 unit.
`default_nettype none

package ipyuv_pkg;

    localparam int PalEntries = 256;
    localparam int PalIdxW    = $clog2(PalEntries);
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 1024;
    localparam int PosW       = 10;
    localparam int GeomW      = 11;
    localparam int LinePairs  = MaxWidth / 2;
    localparam int LineAddrW  = $clog2(LinePairs);
    localparam int CompW      = 8;
    localparam int AccW       = 24;

    // Q16 BT.601 coefficients (magnitudes; signs applied in the sums)
    localparam logic [15:0] CoefYR  = 16'd16843;
    localparam logic [15:0] CoefYG  = 16'd33030;
    localparam logic [15:0] CoefYB  = 16'd6423;
    localparam logic [15:0] CoefCbR = 16'd9699;
    localparam logic [15:0] CoefCbG = 16'd19071;
    localparam logic [15:0] CoefCbB = 16'd28770;
    localparam logic [15:0] CoefCrR = 16'd28770;
    localparam logic [15:0] CoefCrG = 16'd24117;
    localparam logic [15:0] CoefCrB = 16'd4653;
    localparam logic [AccW-1:0] OffsY = AccW'(16 << 16);
    localparam logic [AccW-1:0] OffsC = AccW'(128 << 16);

    localparam logic [GeomW-1:0] WidthReset  = GeomW'(320);
    localparam logic [GeomW-1:0] HeightReset = GeomW'(256);
    localparam logic [GeomW-1:0] GeomMin     = GeomW'(2);
    localparam logic [GeomW-1:0] WidthMax    = GeomW'(MaxWidth);
    localparam logic [GeomW-1:0] HeightMax   = GeomW'(MaxHeight);

    // Palette entry: Y in the top byte, then Cb, then Cr
    typedef logic [3*CompW-1:0] ycc_t;

    typedef enum logic
    {
        KindPalette = 1'b0,
        KindPixel   = 1'b1
    } in_kind_t;

    typedef enum logic
    {
        OutLuma   = 1'b0,
        OutChroma = 1'b1
    } out_kind_t;

    typedef enum logic
    {
        RegFrameWidth  = 1'b0,
        RegFrameHeight = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic load;
        logic advance;
    } csc_ctl_t;

    typedef struct packed
    {
        logic               en;
        logic [PalIdxW-1:0] cur;
        logic [PalIdxW-1:0] left;
        logic [PalIdxW-1:0] up_left;
        logic [PalIdxW-1:0] up;
    } pal_rd_req_t;

    typedef struct packed
    {
        ycc_t cur;
        ycc_t left;
        ycc_t up_left;
        ycc_t up;
    } pal_rd_data_t;

    function automatic logic [GeomW-1:0] clamp_geom(
        input logic [GeomW-1:0] v,
        input logic [GeomW-1:0] hi
    );
        logic [GeomW-1:0] r;
        r = v;
        if (v < GeomMin)
        begin
            r = GeomMin;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ipyuv_csc.sv
// RGB to BT.601 YCbCr conversion: registered products, then registered sums.
`default_nettype none

module ipyuv_csc
(
    input  wire logic                   clk,
    input  wire ipyuv_pkg::csc_ctl_t    ctl,
    input  wire logic [7:0]             red,
    input  wire logic [7:0]             green,
    input  wire logic [7:0]             blue,
    output ipyuv_pkg::ycc_t             ycc
);

    localparam int AccW = ipyuv_pkg::AccW;

    logic [AccW-1:0] prod_next [9];
    logic [AccW-1:0] prod_reg  [9];
    logic [AccW-1:0] y_sum;
    logic [AccW-1:0] cb_sum;
    logic [AccW-1:0] cr_sum;
    ipyuv_pkg::ycc_t ycc_reg;

    always_comb
    begin
        prod_next[0] = AccW'(red)   * AccW'(ipyuv_pkg::CoefYR);
        prod_next[1] = AccW'(green) * AccW'(ipyuv_pkg::CoefYG);
        prod_next[2] = AccW'(blue)  * AccW'(ipyuv_pkg::CoefYB);
        prod_next[3] = AccW'(red)   * AccW'(ipyuv_pkg::CoefCbR);
        prod_next[4] = AccW'(green) * AccW'(ipyuv_pkg::CoefCbG);
        prod_next[5] = AccW'(blue)  * AccW'(ipyuv_pkg::CoefCbB);
        prod_next[6] = AccW'(red)   * AccW'(ipyuv_pkg::CoefCrR);
        prod_next[7] = AccW'(green) * AccW'(ipyuv_pkg::CoefCrG);
        prod_next[8] = AccW'(blue)  * AccW'(ipyuv_pkg::CoefCrB);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Every true sum is non-negative and below 2^24, so wraparound is harmless
    assign y_sum  = prod_reg[0] + prod_reg[1] + prod_reg[2] + ipyuv_pkg::OffsY;
    assign cb_sum = prod_reg[5] + ipyuv_pkg::OffsC - prod_reg[3] - prod_reg[4];
    assign cr_sum = prod_reg[6] + ipyuv_pkg::OffsC - prod_reg[7] - prod_reg[8];

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            ycc_reg <= {y_sum[AccW-1:16], cb_sum[AccW-1:16], cr_sum[AccW-1:16]};
        end
    end

    assign ycc = ycc_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ipyuv_palette.sv
// Palette store: two mirrored copies, each with two registered read ports.
`default_nettype none

module ipyuv_palette
(
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [ipyuv_pkg::PalIdxW-1:0]       waddr,
    input  wire ipyuv_pkg::ycc_t                     wdata,
    input  wire ipyuv_pkg::pal_rd_req_t              rd_req,
    output ipyuv_pkg::pal_rd_data_t                  rd_data
);

    ipyuv_pkg::ycc_t pal_mem_a [ipyuv_pkg::PalEntries];
    ipyuv_pkg::ycc_t pal_mem_b [ipyuv_pkg::PalEntries];
    ipyuv_pkg::ycc_t cur_reg;
    ipyuv_pkg::ycc_t left_reg;
    ipyuv_pkg::ycc_t up_left_reg;
    ipyuv_pkg::ycc_t up_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pal_mem_a[waddr] <= wdata;
            pal_mem_b[waddr] <= wdata;
        end
        // hold read data while the consumer stalls
        if (rd_req.en)
        begin
            cur_reg     <= pal_mem_a[rd_req.cur];
            left_reg    <= pal_mem_a[rd_req.left];
            up_left_reg <= pal_mem_b[rd_req.up_left];
            up_reg      <= pal_mem_b[rd_req.up];
        end
    end

    assign rd_data.cur     = cur_reg;
    assign rd_data.left    = left_reg;
    assign rd_data.up_left = up_left_reg;
    assign rd_data.up      = up_reg;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_pixel_to_yuv420_unit.sv
// Top level of the indexed pixel to YUV 4:2:0 unit.
//
// Input stream (s_*): tuser selects a palette write (0) or a pixel index (1).
// A palette write converts its RGB colour to Y/Cb/Cr and stores it; it makes
// no output. A pixel emits one luma transfer; on odd rows at odd columns it
// then emits a second transfer with the Cb/Cr average of its 2x2 block.
// m_tlast marks the last transfer caused by an input item.
// A result passes the line store read, conversion, palette read and output
// register stages before it is valid on m_*.
// Throughput: one input item per cycle while the output does not stall; the
// output register sends one result per cycle while m_tready is high, so a
// pixel that also carries chroma holds the pipe while its chroma is sent.
// The APB port sets frame width and height; any write rewinds the raster
// position to row 0, column 0. Write only while the unit is idle.
// Reset clears the pipeline, the raster position and the geometry registers
// (320 x 256); palette and line store hold garbage until written.
// When m_tready is low the output register holds and the pipeline fills up;
// s_tready drops only once every stage is occupied.
`default_nettype none
`include "indexed_pixel_to_yuv420_unit_assert.svh"

module indexed_pixel_to_yuv420_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24], pixel_index[39:32]
    input  wire logic [39:0] s_tdata,
    // kind[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // sample_row[9:0], sample_col[19:10], luma[27:20], chroma_blue[35:28],
    // chroma_red[43:36], zero[47:44]
    output logic [47:0]      m_tdata,
    // out_kind[0]
    output logic             m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PosW      = ipyuv_pkg::PosW;
    localparam int GeomW     = ipyuv_pkg::GeomW;
    localparam int IdxW      = ipyuv_pkg::PalIdxW;
    localparam int LineAddrW = ipyuv_pkg::LineAddrW;
    localparam int CompW     = ipyuv_pkg::CompW;

    // configuration and raster position
    logic [GeomW-1:0] frame_width_reg;
    logic [GeomW-1:0] frame_height_reg;
    logic [GeomW-1:0] width_eff;
    logic [GeomW-1:0] height_eff;
    logic [PosW-1:0]  col_reg;
    logic [PosW-1:0]  row_reg;
    logic [PosW-1:0]  col_next;
    logic [PosW-1:0]  row_next;
    logic [GeomW-1:0] col_inc;
    logic [GeomW-1:0] row_inc;
    logic [IdxW-1:0]  prev_pix_reg;
    logic             cfg_we;

    // input fields
    ipyuv_pkg::in_kind_t in_kind;
    logic [IdxW-1:0]     in_entry;
    logic [CompW-1:0]    in_red;
    logic [CompW-1:0]    in_green;
    logic [CompW-1:0]    in_blue;
    logic [IdxW-1:0]     in_pix;
    logic                accept;
    logic                pix_accept;

    // line store of the previous even row, one column pair per entry
    logic [2*IdxW-1:0]   line_mem [ipyuv_pkg::LinePairs];
    logic [2*IdxW-1:0]   line_rd_reg;
    logic                line_we;
    logic                line_re;
    logic [LineAddrW-1:0] line_addr;

    // stage 1
    logic                s1_valid_reg;
    ipyuv_pkg::in_kind_t s1_kind_reg;
    logic [IdxW-1:0]     s1_entry_reg;
    logic [PosW-1:0]     s1_row_reg;
    logic [PosW-1:0]     s1_col_reg;
    logic                s1_chroma_reg;
    logic [IdxW-1:0]     s1_pix_reg;
    logic [IdxW-1:0]     s1_prev_reg;

    // stage 2
    logic                s2_valid_reg;
    ipyuv_pkg::in_kind_t s2_kind_reg;
    logic [IdxW-1:0]     s2_entry_reg;
    logic [PosW-1:0]     s2_row_reg;
    logic [PosW-1:0]     s2_col_reg;
    logic                s2_chroma_reg;
    logic [IdxW-1:0]     s2_pix_reg;
    logic [IdxW-1:0]     s2_prev_reg;
    logic [IdxW-1:0]     s2_up_left_reg;
    logic [IdxW-1:0]     s2_up_reg;

    // stage 3 (palette read data)
    logic                s3_valid_reg;
    logic [PosW-1:0]     s3_row_reg;
    logic [PosW-1:0]     s3_col_reg;
    logic                s3_chroma_reg;

    // output register
    logic                o_valid_reg;
    logic                o_phase_reg;
    logic                o_chroma_reg;
    logic [PosW-1:0]     o_row_reg;
    logic [PosW-1:0]     o_col_reg;
    logic [CompW-1:0]    o_luma_reg;
    logic [CompW-1:0]    o_cb_reg;
    logic [CompW-1:0]    o_cr_reg;

    // flow control
    logic o_done;
    logic o_free;
    logic s3_adv;
    logic s3_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic s1_free;

    ipyuv_pkg::csc_ctl_t     csc_ctl;
    ipyuv_pkg::ycc_t         csc_ycc;
    ipyuv_pkg::pal_rd_req_t  pal_req;
    ipyuv_pkg::pal_rd_data_t pal_data;
    logic                    pal_we;
    logic [CompW+1:0]        cb_sum;
    logic [CompW+1:0]        cr_sum;

    assign in_kind  = ipyuv_pkg::in_kind_t'(s_tuser);
    assign in_entry = s_tdata[7:0];
    assign in_red   = s_tdata[15:8];
    assign in_green = s_tdata[23:16];
    assign in_blue  = s_tdata[31:24];
    assign in_pix   = s_tdata[39:32];

    assign o_done  = o_valid_reg && m_tready && (o_phase_reg || !o_chroma_reg);
    assign o_free  = !o_valid_reg || o_done;
    assign s3_adv  = s3_valid_reg && o_free;
    assign s3_free = !s3_valid_reg || o_free;
    assign s2_adv  = s2_valid_reg && ((s2_kind_reg == ipyuv_pkg::KindPalette) || s3_free);
    assign s2_free = !s2_valid_reg || s2_adv;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s2_free;

    assign s_tready   = s1_free;
    assign accept     = s_tvalid && s1_free;
    assign pix_accept = accept && (in_kind == ipyuv_pkg::KindPixel);

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (ipyuv_pkg::cfg_reg_t'(paddr[2]))
            ipyuv_pkg::RegFrameWidth:  prdata = 32'(frame_width_reg);
            ipyuv_pkg::RegFrameHeight: prdata = 32'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign width_eff  = ipyuv_pkg::clamp_geom(frame_width_reg, ipyuv_pkg::WidthMax);
    assign height_eff = ipyuv_pkg::clamp_geom(frame_height_reg, ipyuv_pkg::HeightMax);

    // ---------------------------------------------------------------- raster
    assign col_inc = GeomW'(col_reg) + GeomW'(1);
    assign row_inc = GeomW'(row_reg) + GeomW'(1);

    always_comb
    begin
        col_next = col_inc[PosW-1:0];
        row_next = row_reg;
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : row_inc[PosW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ipyuv_pkg::WidthReset;
            frame_height_reg <= ipyuv_pkg::HeightReset;
            col_reg          <= '0;
            row_reg          <= '0;
            prev_pix_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (ipyuv_pkg::cfg_reg_t'(paddr[2]))
                    ipyuv_pkg::RegFrameWidth:  frame_width_reg  <= pwdata[GeomW-1:0];
                    ipyuv_pkg::RegFrameHeight: frame_height_reg <= pwdata[GeomW-1:0];
                    default:                   frame_width_reg  <= frame_width_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (pix_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (pix_accept)
            begin
                prev_pix_reg <= in_pix;
            end
        end
    end

    // ---------------------------------------------------------------- line store
    // Even rows store each column pair once its odd column arrives
    assign line_addr = col_reg[PosW-1:1];
    assign line_we   = pix_accept && !row_reg[0] && col_reg[0];
    assign line_re   = pix_accept && row_reg[0];

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_addr] <= {in_pix, prev_pix_reg};
        end
        if (line_re)
        begin
            line_rd_reg <= line_mem[line_addr];
        end
    end

    // ---------------------------------------------------------------- pipeline
    assign csc_ctl.load    = accept;
    assign csc_ctl.advance = s1_adv;

    ipyuv_csc u_csc
    (
        .clk   (clk),
        .ctl   (csc_ctl),
        .red   (in_red),
        .green (in_green),
        .blue  (in_blue),
        .ycc   (csc_ycc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            o_phase_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg && (s2_kind_reg == ipyuv_pkg::KindPixel);
            end
            if (o_free)
            begin
                o_valid_reg <= s3_valid_reg;
                o_phase_reg <= 1'b0;
            end
            else if (m_tready)
            begin
                // luma sent, chroma of the same pixel follows
                o_phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= in_kind;
            s1_entry_reg  <= in_entry;
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            s1_chroma_reg <= row_reg[0] && col_reg[0];
            s1_pix_reg    <= in_pix;
            s1_prev_reg   <= prev_pix_reg;
        end
        if (s1_adv)
        begin
            s2_kind_reg    <= s1_kind_reg;
            s2_entry_reg   <= s1_entry_reg;
            s2_row_reg     <= s1_row_reg;
            s2_col_reg     <= s1_col_reg;
            s2_chroma_reg  <= s1_chroma_reg;
            s2_pix_reg     <= s1_pix_reg;
            s2_prev_reg    <= s1_prev_reg;
            s2_up_left_reg <= line_rd_reg[IdxW-1:0];
            s2_up_reg      <= line_rd_reg[2*IdxW-1:IdxW];
        end
        if (pal_req.en)
        begin
            s3_row_reg    <= s2_row_reg;
            s3_col_reg    <= s2_col_reg;
            s3_chroma_reg <= s2_chroma_reg;
        end
        if (s3_adv)
        begin
            o_chroma_reg <= s3_chroma_reg;
            o_row_reg    <= s3_row_reg;
            o_col_reg    <= s3_col_reg;
            o_luma_reg   <= pal_data.cur[3*CompW-1:2*CompW];
            o_cb_reg     <= cb_sum[CompW+1:2];
            o_cr_reg     <= cr_sum[CompW+1:2];
        end
    end

    // ---------------------------------------------------------------- palette
    // Writes and reads issue from the same stage, so program order holds
    assign pal_we          = s2_valid_reg && (s2_kind_reg == ipyuv_pkg::KindPalette);
    assign pal_req.en      = s2_valid_reg && (s2_kind_reg == ipyuv_pkg::KindPixel) && s3_free;
    assign pal_req.cur     = s2_pix_reg;
    assign pal_req.left    = s2_prev_reg;
    assign pal_req.up_left = s2_up_left_reg;
    assign pal_req.up      = s2_up_reg;

    ipyuv_palette u_palette
    (
        .clk     (clk),
        .we      (pal_we),
        .waddr   (s2_entry_reg),
        .wdata   (csc_ycc),
        .rd_req  (pal_req),
        .rd_data (pal_data)
    );

    assign cb_sum = (CompW+2)'(pal_data.cur[2*CompW-1:CompW])
                  + (CompW+2)'(pal_data.left[2*CompW-1:CompW])
                  + (CompW+2)'(pal_data.up_left[2*CompW-1:CompW])
                  + (CompW+2)'(pal_data.up[2*CompW-1:CompW]);
    assign cr_sum = (CompW+2)'(pal_data.cur[CompW-1:0])
                  + (CompW+2)'(pal_data.left[CompW-1:0])
                  + (CompW+2)'(pal_data.up_left[CompW-1:0])
                  + (CompW+2)'(pal_data.up[CompW-1:0]);

    // ---------------------------------------------------------------- output
    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_phase_reg ? ipyuv_pkg::OutChroma : ipyuv_pkg::OutLuma;
    assign m_tlast  = o_phase_reg || !o_chroma_reg;
    assign m_tdata  = o_phase_reg
                    ? {4'b0, o_cr_reg, o_cb_reg, {CompW{1'b0}},
                       {1'b0, o_col_reg[PosW-1:1]}, {1'b0, o_row_reg[PosW-1:1]}}
                    : {4'b0, {CompW{1'b0}}, {CompW{1'b0}}, o_luma_reg,
                       o_col_reg, o_row_reg};

    // ---------------------------------------------------------------- checks
    `IPYUV_ASSERT_IMPL(a_phase_needs_chroma, clk, rst_n, o_phase_reg, o_valid_reg && o_chroma_reg, "chroma phase on a pixel without chroma")
    `IPYUV_ASSERT_NEXT(a_luma_then_chroma, clk, rst_n, o_valid_reg && !o_phase_reg && o_chroma_reg && m_tready, o_valid_reg && o_phase_reg, "chroma transfer did not follow its luma")
    `IPYUV_ASSERT_NEXT(a_s3_holds, clk, rst_n, s3_valid_reg && !o_free, s3_valid_reg, "palette read data lost while output stalled")
    `IPYUV_ASSERT_IMPL(a_pal_rw_excl, clk, rst_n, pal_we, !pal_req.en, "palette write and read issued together")

endmodule

`default_nettype wire

// File: tb/ipyuv_stream_checker.sv
`timescale 1ns / 100ps
// Stream checker of the indexed pixel to YUV 4:2:0 unit: predicts and compares every result.
module ipyuv_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          samples_pending
);

    typedef struct packed
    {
        ipyuv_pkg::out_kind_t kind;
        logic [9:0]           row;
        logic [9:0]           col;
        logic [7:0]           luma;
        logic [7:0]           cb;
        logic [7:0]           cr;
        logic                 last;
    } yuv_sample_t;

    // BT.601 coefficients in Q16
    localparam int Q16_Y_R  = 16843;
    localparam int Q16_Y_G  = 33030;
    localparam int Q16_Y_B  = 6423;
    localparam int Q16_CB_R = 9699;
    localparam int Q16_CB_G = 19071;
    localparam int Q16_CB_B = 28770;
    localparam int Q16_CR_R = 28770;
    localparam int Q16_CR_G = 24117;
    localparam int Q16_CR_B = 4653;

    ipyuv_pkg::ycc_t ycc_palette [256];
    logic [7:0]  row_above [1024];
    logic [7:0]  left_index = '0;
    logic [10:0] width_reg = 11'd320;
    logic [10:0] height_reg = 11'd256;
    logic [9:0]  col_pos = '0;
    logic [9:0]  row_pos = '0;
    yuv_sample_t expected_samples [$];
    int          errors = 0;
    int          pending_n = 0;

    assign mismatch_count  = errors;
    assign samples_pending = pending_n;

    function automatic ipyuv_pkg::ycc_t rgb_to_ycc(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b);
        int ri;
        int gi;
        int bi;
        int y;
        int cb;
        int cr;
        ri = r;
        gi = g;
        bi = b;
        y  = (Q16_Y_R * ri + Q16_Y_G * gi + Q16_Y_B * bi + (16 << 16)) >> 16;
        cb = (-Q16_CB_R * ri - Q16_CB_G * gi + Q16_CB_B * bi + (128 << 16)) >> 16;
        cr = (Q16_CR_R * ri - Q16_CR_G * gi - Q16_CR_B * bi + (128 << 16)) >> 16;
        return {y[7:0], cb[7:0], cr[7:0]};
    endfunction

    function automatic int size_in_effect(input logic [10:0] v);
        int n;
        n = v;
        if (n < 2)
        begin
            n = 2;
        end
        else if (n > 1024)
        begin
            n = 1024;
        end
        return n;
    endfunction

    function automatic string show(input yuv_sample_t s);
        return $sformatf("kind=%0d row=%0d col=%0d y=%0d cb=%0d cr=%0d last=%0d",
                         s.kind, s.row, s.col, s.luma, s.cb, s.cr, s.last);
    endfunction

    task automatic note_mismatch(input string what);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic predict_pixel(input logic [7:0] pix);
        ipyuv_pkg::ycc_t cur;
        ipyuv_pkg::ycc_t up_left;
        ipyuv_pkg::ycc_t up;
        ipyuv_pkg::ycc_t left;
        yuv_sample_t     s;
        logic [9:0]      sum_cb;
        logic [9:0]      sum_cr;
        int              col;
        int              row;
        cur = ycc_palette[pix];
        s = '0;
        s.kind = ipyuv_pkg::OutLuma;
        s.row  = row_pos;
        s.col  = col_pos;
        s.luma = cur[23:16];
        s.last = !(row_pos[0] && col_pos[0]);
        expected_samples.push_back(s);
        if (row_pos[0] && col_pos[0])
        begin
            up_left = ycc_palette[row_above[col_pos - 10'd1]];
            up      = ycc_palette[row_above[col_pos]];
            left    = ycc_palette[left_index];
            sum_cb = {2'b0, up_left[15:8]} + {2'b0, up[15:8]} + {2'b0, left[15:8]}
                   + {2'b0, cur[15:8]};
            sum_cr = {2'b0, up_left[7:0]} + {2'b0, up[7:0]} + {2'b0, left[7:0]}
                   + {2'b0, cur[7:0]};
            s = '0;
            s.kind = ipyuv_pkg::OutChroma;
            s.row  = row_pos >> 1;
            s.col  = col_pos >> 1;
            s.cb   = sum_cb[9:2];
            s.cr   = sum_cr[9:2];
            s.last = 1'b1;
            expected_samples.push_back(s);
        end
        // Even rows fill the line store for the odd row below
        if (!row_pos[0])
        begin
            row_above[col_pos] = pix;
        end
        left_index = pix;
        col = col_pos + 1;
        row = row_pos;
        if (col >= size_in_effect(width_reg))
        begin
            col = 0;
            row = row + 1;
            if (row >= size_in_effect(height_reg))
            begin
                row = 0;
            end
        end
        col_pos = col[9:0];
        row_pos = row[9:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        yuv_sample_t got;
        yuv_sample_t want;
        logic [31:0] reg_value;
        if (!rst_n)
        begin
            width_reg  = 11'd320;
            height_reg = 11'd256;
            left_index = '0;
            col_pos    = '0;
            row_pos    = '0;
            expected_samples.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (ipyuv_pkg::cfg_reg_t'(paddr[2]) == ipyuv_pkg::RegFrameWidth)
                    begin
                        width_reg = pwdata[10:0];
                    end
                    else
                    begin
                        height_reg = pwdata[10:0];
                    end
                    col_pos = '0;
                    row_pos = '0;
                end
                else
                begin
                    reg_value = (ipyuv_pkg::cfg_reg_t'(paddr[2]) == ipyuv_pkg::RegFrameWidth)
                              ? {21'b0, width_reg} : {21'b0, height_reg};
                    if (prdata !== reg_value)
                    begin
                        note_mismatch($sformatf("register read at %0d: expected %0h, got %0h",
                                                paddr, reg_value, prdata));
                    end
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.kind = ipyuv_pkg::out_kind_t'(m_tuser);
                got.row  = m_tdata[9:0];
                got.col  = m_tdata[19:10];
                got.luma = m_tdata[27:20];
                got.cb   = m_tdata[35:28];
                got.cr   = m_tdata[43:36];
                got.last = m_tlast;
                if (expected_samples.size() == 0)
                begin
                    note_mismatch({"unexpected sample ", show(got)});
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got !== want || m_tdata[47:44] !== 4'd0)
                    begin
                        note_mismatch($sformatf("expected %s; got %s pad=%0h",
                                                show(want), show(got), m_tdata[47:44]));
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ipyuv_pkg::KindPalette)
                begin
                    ycc_palette[s_tdata[7:0]] = rgb_to_ycc(s_tdata[15:8], s_tdata[23:16],
                                                           s_tdata[31:24]);
                end
                else
                begin
                    predict_pixel(s_tdata[39:32]);
                end
            end
        end
        pending_n = expected_samples.size();
    end

endmodule

// File: tb/indexed_pixel_to_yuv420_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top of the indexed pixel to YUV 4:2:0 unit: stimulus, idling and verdict.
module indexed_pixel_to_yuv420_unit_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          samples_pending;

    int          send_idle_pct = 29;
    int          recv_idle_pct = 82;
    bit          entry_written [256];
    logic [7:0]  written_entries [$];

    // Frame geometry register values, item count and share of palette writes per phase
    int phase_width [7]       = '{2, 0, 7, 1, 16, 10, 2047};
    int phase_height [7]      = '{2, 5, 4, 1, 6, 2047, 2};
    int phase_items [7]       = '{18, 18, 18, 18, 18, 18, 1030};
    int phase_palette_pct [7] = '{15, 15, 15, 15, 15, 15, 0};

    indexed_pixel_to_yuv420_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ipyuv_stream_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .samples_pending (samples_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        #5_000_000;
        $display("indexed_pixel_to_yuv420_unit verification failed");
        $finish;
    end

    // Call at a falling edge; returns at the falling edge after the transfer, valid still high
    task automatic send_item(input ipyuv_pkg::in_kind_t kind, input logic [39:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_palette(input logic [7:0] idx, input logic [7:0] r,
                                 input logic [7:0] g, input logic [7:0] b);
        send_item(ipyuv_pkg::KindPalette, {8'($urandom()), b, g, r, idx});
        if (!entry_written[idx])
        begin
            entry_written[idx] = 1'b1;
            written_entries.push_back(idx);
        end
    endtask

    task automatic send_pixel(input logic [7:0] pix);
        send_item(ipyuv_pkg::KindPixel, {pix, $urandom()});
    endtask

    function automatic logic [7:0] random_component();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Hold the sender until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (samples_pending != 0);
    endtask

    task automatic apb_access(input logic wr, input ipyuv_pkg::cfg_reg_t sel,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input int w, input int h);
        drain_results();
        // Let trailing palette writes leave the pipeline
        repeat (8) @(negedge clk);
        apb_access(1'b1, ipyuv_pkg::RegFrameWidth, ($urandom() & ~32'h7FF) | 32'(w));
        apb_access(1'b0, ipyuv_pkg::RegFrameWidth, $urandom());
        apb_access(1'b1, ipyuv_pkg::RegFrameHeight, ($urandom() & ~32'h7FF) | 32'(h));
        apb_access(1'b0, ipyuv_pkg::RegFrameHeight, $urandom());
    endtask

    initial
    begin
        int wait_cycles;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 4 x 3 frame, primaries and extremes, palette update under the line store
        set_geometry(4, 3);
        write_palette(8'd0, 8'd0, 8'd0, 8'd0);
        write_palette(8'd255, 8'd255, 8'd255, 8'd255);
        write_palette(8'd1, 8'd255, 8'd0, 8'd0);
        write_palette(8'd2, 8'd0, 8'd255, 8'd0);
        write_palette(8'd3, 8'd0, 8'd0, 8'd255);
        write_palette(8'd170, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd2);
        write_palette(8'd255, 8'd16, 8'd128, 8'd240);
        send_pixel(8'd3);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd2);
        send_pixel(8'd3);
        send_pixel(8'd170);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);

        for (int p = 0; p < 7; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 82;
            end
            else if (p < 4)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_geometry(phase_width[p], phase_height[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    drain_results();
                end
                if ($urandom_range(0, 99) < phase_palette_pct[p])
                begin
                    write_palette(8'($urandom_range(0, 255)), random_component(),
                                  random_component(), random_component());
                end
                else
                begin
                    send_pixel(written_entries[$urandom_range(0, written_entries.size() - 1)]);
                end
            end
        end

        s_tvalid <= 1'b0;
        for (wait_cycles = 0; samples_pending != 0 && wait_cycles < 20000; wait_cycles++)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && samples_pending == 0)
        begin
            $display("indexed_pixel_to_yuv420_unit verification clean");
        end
        else
        begin
            $display("indexed_pixel_to_yuv420_unit verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ipyuv_pkg.sv
hw/rtl/ipyuv_csc.sv
hw/rtl/ipyuv_palette.sv
hw/rtl/indexed_pixel_to_yuv420_unit.sv
tb/ipyuv_stream_checker.sv
tb/indexed_pixel_to_yuv420_unit_tb.sv
